// ===== design/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } shs_state_type;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_FILL  = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD  = 3'd7;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   typedef struct packed {
      logic       push;
      logic [7:0] push_byte;
      logic       load_vars;
      logic       do_round;
      logic [5:0] round_idx;
      logic       add_hash;
      logic       reinit;
   } shs_ctrl_type;

   typedef struct packed {
      shs_state_type state;
      logic [5:0]    fill;
      logic [2:0]    word;
   } shs_status_type;

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

endpackage

// ===== design/shs_channels.sv =====
// ----------------------------------------------------------------------------
// shs_channels
// Valid/ready channel interfaces for message bytes and digest words.
// ----------------------------------------------------------------------------
interface shs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       byte_present;
   logic       message_end;

   modport source (output valid, message_byte, byte_present, message_end, input ready);
   modport sink   (input valid, message_byte, byte_present, message_end, output ready);
endinterface

interface shs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;

   modport source (output valid, digest_word, word_number, last_word, input ready);
   modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

// ===== design/shs_window.sv =====
// ----------------------------------------------------------------------------
// shs_window
// Sixteen-word message window: collects block bytes, then extends the schedule.
// ----------------------------------------------------------------------------
module shs_window import shs_pkg::*; (
   input  logic         clock,
   input  shs_ctrl_type ctrl,
   output logic [31:0]  w_cur
);

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] new_w;

   // The window is one 512-bit shift line: bytes enter at the bottom, so the
   // first byte of a block ends up as the top byte of word zero.
   always_comb begin
      new_w = w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);
      w_in  = w_ff;
      if (ctrl.push) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = {w_ff[i][23:0], w_ff[i+1][31:24]};
         end
         w_in[15] = {w_ff[15][23:0], ctrl.push_byte};
      end else if (ctrl.do_round) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = new_w;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   assign w_cur = w_ff[0];

endmodule

// ===== design/shs_round.sv =====
// ----------------------------------------------------------------------------
// shs_round
// Shared round unit: working variables, one round per cycle, and hash state.
// ----------------------------------------------------------------------------
module shs_round import shs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  shs_ctrl_type ctrl,
   input  logic [31:0]  w_cur,
   input  logic [2:0]   word_sel,
   output logic [31:0]  digest_word
);

   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [31:0] var_ff  [8];
   logic [31:0] var_in  [8];
   logic [31:0] t1;
   logic [31:0] t2;

   always_comb begin
      t1 = var_ff[7] + big_sigma1(var_ff[4])
         + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
         + ROUND_K[ctrl.round_idx] + w_cur;
      t2 = big_sigma0(var_ff[0])
         + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   end

   always_comb begin
      var_in = var_ff;
      if (ctrl.load_vars) begin
         var_in = hash_ff;
      end else if (ctrl.do_round) begin
         var_in[7] = var_ff[6];
         var_in[6] = var_ff[5];
         var_in[5] = var_ff[4];
         var_in[4] = var_ff[3] + t1;
         var_in[3] = var_ff[2];
         var_in[2] = var_ff[1];
         var_in[1] = var_ff[0];
         var_in[0] = t1 + t2;
      end
   end

   always_comb begin
      hash_in = hash_ff;
      if (ctrl.reinit) begin
         hash_in = INIT_H;
      end else if (ctrl.add_hash) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + var_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= INIT_H;
      end else begin
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      var_ff <= var_in;
   end

   assign digest_word = hash_ff[word_sel];

endmodule

// ===== design/shs_seq.sv =====
// ----------------------------------------------------------------------------
// shs_seq
// Sequencer: byte counting, padding, round count and digest word delivery.
// ----------------------------------------------------------------------------
module shs_seq import shs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  logic [7:0]     message_byte,
   input  logic           byte_present,
   input  logic           message_end,
   input  logic           out_ready,
   output shs_ctrl_type   ctrl,
   output shs_status_type status
);

   shs_state_type state_ff, state_in;
   logic [5:0]    fill_ff,  fill_in;
   logic [60:0]   total_ff, total_in;
   logic [5:0]    round_ff, round_in;
   logic [2:0]    word_ff,  word_in;
   logic          pad_ff,   pad_in;
   logic          mark_ff,  mark_in;
   logic          len_ff,   len_in;
   logic          done_ff,  done_in;
   logic          len_mode;
   logic [63:0]   len_shifted;
   logic [7:0]    pad_byte;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (byte_present && fill_ff == LAST_FILL) begin
                  state_in = ST_ROUND;
               end else if (message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == LAST_FILL) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (done_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (out_ready && word_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Once the marker byte is in, the length field starts at offset 56 and
   // runs to the end of that block.
   always_comb begin
      len_mode    = mark_ff && (len_ff || fill_ff == LEN_OFFSET);
      len_shifted = {total_ff, 3'b000} << {fill_ff[2:0], 3'b000};
      if (!mark_ff) begin
         pad_byte = PAD_MARK;
      end else if (len_mode) begin
         pad_byte = len_shifted[63:56];
      end else begin
         pad_byte = 8'h00;
      end
   end

   always_comb begin
      ctrl           = '0;
      ctrl.round_idx = round_ff;
      fill_in        = fill_ff;
      total_in       = total_ff;
      round_in       = round_ff;
      word_in        = word_ff;
      pad_in         = pad_ff;
      mark_in        = mark_ff;
      len_in         = len_ff;
      done_in        = done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               pad_in = message_end;
               if (byte_present) begin
                  ctrl.push      = 1'b1;
                  ctrl.push_byte = message_byte;
                  fill_in        = fill_ff + 6'd1;
                  total_in       = total_ff + 61'd1;
                  ctrl.load_vars = (fill_ff == LAST_FILL);
               end
            end
         end
         ST_PAD: begin
            ctrl.push      = 1'b1;
            ctrl.push_byte = pad_byte;
            fill_in        = fill_ff + 6'd1;
            mark_in        = 1'b1;
            if (len_mode) begin
               len_in = 1'b1;
            end
            if (fill_ff == LAST_FILL) begin
               ctrl.load_vars = 1'b1;
               done_in        = len_mode;
            end
         end
         ST_ROUND: begin
            ctrl.do_round = 1'b1;
            round_in      = round_ff + 6'd1;
         end
         ST_FINAL: begin
            ctrl.add_hash = 1'b1;
         end
         ST_OUT: begin
            if (out_ready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == LAST_WORD) begin
                  ctrl.reinit = 1'b1;
                  fill_in     = '0;
                  total_in    = '0;
                  pad_in      = 1'b0;
                  mark_in     = 1'b0;
                  len_in      = 1'b0;
                  done_in     = 1'b0;
               end
            end
         end
         default: begin
            fill_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         total_ff <= '0;
         round_ff <= '0;
         word_ff  <= '0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         len_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         round_ff <= round_in;
         word_ff  <= word_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         len_ff   <= len_in;
         done_ff  <= done_in;
      end
   end

   assign status.state = state_ff;
   assign status.fill  = fill_ff;
   assign status.word  = word_ff;

endmodule

// ===== design/sha256_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// SHA-256 hasher that takes a message one byte per transfer.
// ----------------------------------------------------------------------------
// Usage: each transfer on req_chan carries one message byte (when byte_present
// is set) and an optional message_end flag. A transfer with the end flag and
// no byte hashes the message as it stands, the empty message included.
// After the end, rsp_chan gives the digest as eight 32-bit transfers, word 0
// (most significant) first, last_word set on word 7; the unit then starts a
// fresh message by itself.
// Timing: a byte that does not complete a 64-byte block leaves the unit ready
// for the next byte. A byte that completes one is pushed, then 64 rounds of the
// shared round unit run at one round a cycle, then the result is added into the hash state.
// An end transfer pads one byte per cycle (64 - f bytes for a fill f below 56,
// otherwise 128 - f), compressing each completed block, then holds each
// digest word until it is taken. req_chan.ready is low throughout.
// Reset (synchronous) loads the initial hash values and empties the counters.
// If the receiver stalls, the current digest word simply stays on rsp_chan.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit import shs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   shs_req_if.sink   req_chan,
   shs_rsp_if.source rsp_chan
);

   shs_ctrl_type   ctrl;
   shs_status_type status;
   logic [31:0]    w_cur;

   shs_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .message_byte (req_chan.message_byte),
      .byte_present (req_chan.byte_present),
      .message_end  (req_chan.message_end),
      .out_ready    (rsp_chan.ready),
      .ctrl         (ctrl),
      .status       (status)
   );

   shs_window u_window (
      .clock (clock),
      .ctrl  (ctrl),
      .w_cur (w_cur)
   );

   shs_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .w_cur       (w_cur),
      .word_sel    (status.word),
      .digest_word (rsp_chan.digest_word)
   );

   assign req_chan.ready       = (status.state == ST_IDLE);
   assign rsp_chan.valid       = (status.state == ST_OUT);
   assign rsp_chan.word_number = status.word;
   assign rsp_chan.last_word   = (status.word == LAST_WORD);

`ifndef NO_ASSERTIONS
   // Input and output never overlap: the digest is delivered while busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("input accepted while digest pending");

   // Rounds only run on a complete block.
   assert property (@(posedge clock) disable iff (reset)
      (status.state == ST_ROUND) |-> (status.fill == 6'd0))
      else $error("compression started on a partial block");

   // Digest words go out in order.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_word) |=>
         (rsp_chan.valid && rsp_chan.word_number == $past(rsp_chan.word_number) + 3'd1))
      else $error("digest word order broken");

   // After the final word the unit is ready for a new message.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_word) |=>
         (req_chan.ready && status.fill == 6'd0 && status.word == 3'd0))
      else $error("unit not restarted after digest");
`endif

endmodule
